// ===== design/uppd_pkg.sv =====
// Shared types and character codes for the URL percent decoder.
`timescale 1ns / 1ps

package uppd_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PCT     = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;

	// Pending escape progress
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	// Up to three output bytes caused by one input byte
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      cnt;
		logic            last;
	} bundle_t;

endpackage

// ===== design/uppd_front.sv =====
// Front end: classifies input bytes, tracks escapes and builds output bundles.
`timescale 1ns / 1ps

module uppd_front
	import uppd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push_ready,
	output logic       push_valid,
	output bundle_t    push_data,
	output logic [1:0] pend
);

	logic [1:0] pend_q;
	logic [7:0] held_q;
	logic [1:0] pend_n;
	logic [7:0] held_n;
	logic [1:0] n;
	logic       do_plain;
	logic       accept;
	logic       b_hex;
	logic [3:0] b_val;
	logic [3:0] h_val;
	logic [7:0] v;
	bundle_t    res;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
			(c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	// Digits map to their low nibble, letters of either case to low nibble plus nine
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	function automatic logic is_kept(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_Z) ||
			(c >= CH_UP_A && c <= CH_UP_Z) || c == CH_BANG || c == CH_DOLLAR ||
			(c >= CH_AMP && c <= CH_SLASH) || c == CH_COLON || c == CH_SEMI ||
			c == CH_EQUALS || c == CH_QUEST || c == CH_AT || c == CH_UNDER;
	endfunction

	assign accept = in_valid && push_ready;
	assign b_hex  = is_hex(in_byte);
	assign b_val  = hex_val(in_byte);
	assign h_val  = hex_val(held_q);
	assign v      = {h_val, b_val};

	always_comb begin
		pend_n   = pend_q;
		held_n   = held_q;
		res      = '0;
		n        = 2'd0;
		do_plain = 1'b0;
		case (pend_q)
			PEND_PCT: begin
				if (b_hex) begin
					held_n = in_byte;
					pend_n = PEND_DIGIT;
				end else begin
					pend_n = PEND_NONE;
					res.data[n] = CH_PCT;
					n = n + 2'd1;
					do_plain = 1'b1;
				end
			end
			PEND_DIGIT: begin
				pend_n = PEND_NONE;
				if (b_hex && !is_kept(v)) begin
					res.data[n] = v;
					n = n + 2'd1;
				end else begin
					res.data[n] = CH_PCT;
					n = n + 2'd1;
					res.data[n] = held_q;
					n = n + 2'd1;
					if (b_hex) begin
						res.data[n] = in_byte;
						n = n + 2'd1;
					end else begin
						do_plain = 1'b1;
					end
				end
			end
			default: begin
				pend_n   = PEND_NONE;
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			if (in_byte == CH_PLUS) begin
				res.data[n] = CH_SPACE;
				n = n + 2'd1;
			end else if (in_byte == CH_PCT) begin
				pend_n = PEND_PCT;
			end else begin
				res.data[n] = in_byte;
				n = n + 2'd1;
			end
		end
		// Flush whatever escape is still open at the end of the string
		if (in_last) begin
			if (pend_n == PEND_PCT) begin
				res.data[n] = CH_PCT;
				n = n + 2'd1;
			end else if (pend_n == PEND_DIGIT) begin
				res.data[n] = CH_PCT;
				n = n + 2'd1;
				res.data[n] = held_n;
				n = n + 2'd1;
			end
			pend_n = PEND_NONE;
		end
		res.cnt  = n;
		res.last = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= 8'd0;
		end else if (accept) begin
			pend_q <= pend_n;
			held_q <= held_n;
		end
	end

	assign push_valid = accept && (n != 2'd0);
	assign push_data  = res;
	assign pend       = pend_q;

endmodule

// ===== design/uppd_queue.sv =====
// Short bundle queue between the front end and the back end.
`timescale 1ns / 1ps

module uppd_queue
	import uppd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	input  bundle_t wr_data,
	output logic    wr_ready,
	output logic    rd_valid,
	output bundle_t rd_data,
	input  logic    rd_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/uppd_back.sv =====
// Back end: serialises bundles into single output bytes through an output register.
`timescale 1ns / 1ps

module uppd_back
	import uppd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  bundle_t    q_data,
	output logic       q_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	bundle_t    cur_q;
	logic       cur_v_q;
	logic [1:0] pos_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;
	logic       load;
	logic       final_byte;
	logic       done;

	assign load       = cur_v_q && (!ov_q || out_ready);
	assign final_byte = (pos_q == cur_q.cnt - 2'd1);
	assign done       = load && final_byte;
	// Take the next bundle as soon as the current one hands over its last byte
	assign q_ready    = !cur_v_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= 2'd0;
			ov_q    <= 1'b0;
		end else begin
			if (q_valid && q_ready) begin
				cur_v_q <= 1'b1;
				pos_q   <= 2'd0;
			end else if (done) begin
				cur_v_q <= 1'b0;
			end else if (load) begin
				pos_q <= pos_q + 2'd1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cur_q <= q_data;
		end
		if (load) begin
			ob_q <= cur_q.data[pos_q];
			ol_q <= cur_q.last && final_byte;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_last  = ol_q;

endmodule

// ===== design/url_percent_decoder.sv =====
// Top level of the URL percent decoder: front end, bundle queue and back end.
//
// Channel   Dir   tdata                  tlast
// s_axis    in    [7:0] in_byte          in_last
// m_axis    out   [7:0] out_byte         out_last
//
// One input byte per cycle is taken while the bundle queue has room.
// The back end sends its output bytes one at a time; an escape that expands to
// two or three literals holds the front end only once the queue fills.
// Output of an accepted request passes the queue, the current bundle and the output register.
// Reset clears the pending escape, the queue, the current bundle and the output valid flag.
// Either side may stall at any time; the queue decouples the two.
`timescale 1ns / 1ps

module url_percent_decoder
	import uppd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	logic       push_valid;
	logic       push_ready;
	bundle_t    push_data;
	logic       pop_valid;
	logic       pop_ready;
	bundle_t    pop_data;
	logic [1:0] pend;

	uppd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pend       (pend)
	);

	uppd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_data  (push_data),
		.wr_ready (push_ready),
		.rd_valid (pop_valid),
		.rd_data  (pop_data),
		.rd_ready (pop_ready)
	);

	uppd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_data    (pop_data),
		.q_ready   (pop_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	assign s_axis_tready = push_ready;

	// A request marked last always yields at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> push_valid)
		else $error("last request produced no output bundle");

	// No escape survives the end of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (pend == PEND_NONE))
		else $error("escape still pending after last request");

	// Bundles never carry a zero count into the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (push_data.cnt != 2'd0))
		else $error("empty bundle pushed");

	// A held digit only follows a '%' or an earlier held digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend == PEND_DIGIT) |-> ($past(pend) == PEND_PCT || $past(pend) == PEND_DIGIT))
		else $error("held digit without a preceding escape start");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the URL percent decoder with a stream driver and monitor.
`timescale 1ns / 1ps

module tb;
	import uppd_pkg::*;

	localparam int N_RANDOM   = 244;
	localparam int QUIET_TAIL = 40;    // no idling once this few requests are left
	localparam int HOLD_AFTER = 80;    // requests sent before the long output hold
	localparam int LONG_HOLD  = 60;
	localparam int SETTLE     = 16;
	localparam int LIMIT_NS   = 2_000_000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
		logic       drain;   // wait for all output before offering this byte
	} enc_char_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} dec_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;

	enc_char_t  enc_chars[$];
	dec_char_t  decoded_due[$];
	dec_char_t  step_out[$];

	logic [1:0] esc_state = PEND_NONE;
	logic [7:0] esc_digit = 8'h00;

	int         n_items;
	int         chars_sent = 0;
	int         chars_seen = 0;
	int         strings_built = 0;
	int         errors = 0;
	int         n_escapes = 0;
	int         n_kept = 0;
	int         n_broken = 0;
	int         gap_left = 0;
	int         stall_left = 0;
	bit         long_hold_done = 1'b0;
	enc_char_t  nxt;
	dec_char_t  want;

	url_percent_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
			(c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] t;
		if (c <= CH_NINE)
			t = c - CH_ZERO;
		else if (c >= CH_LO_A)
			t = c - CH_LO_A + 8'd10;
		else
			t = c - CH_UP_A + 8'd10;
		return t[3:0];
	endfunction

	// Characters that an escape may not produce; such escapes stay literal
	function automatic logic stays_escaped(input logic [7:0] v);
		return (v >= CH_ZERO && v <= CH_NINE) || (v >= CH_LO_A && v <= CH_LO_Z) ||
			(v >= CH_UP_A && v <= CH_UP_Z) || v == CH_BANG || v == CH_DOLLAR ||
			(v >= CH_AMP && v <= CH_SLASH) || v == CH_COLON || v == CH_SEMI ||
			v == CH_EQUALS || v == CH_QUEST || v == CH_AT || v == CH_UNDER;
	endfunction

	task automatic emit_char(input logic [7:0] c);
		dec_char_t d;
		d.ch  = c;
		d.eos = 1'b0;
		step_out = {step_out, d};
	endtask

	task automatic plain_char(input logic [7:0] c);
		if (c == CH_PLUS)
			emit_char(CH_SPACE);
		else if (c == CH_PCT)
			esc_state = PEND_PCT;
		else
			emit_char(c);
	endtask

	// Advance the escape state by one byte and queue the decoded output it yields
	task automatic decode_char(input logic [7:0] c, input logic eos);
		logic [7:0] v;
		dec_char_t  d;
		step_out.delete();
		case (esc_state)
			PEND_PCT: begin
				if (is_hex_char(c)) begin
					esc_digit = c;
					esc_state = PEND_DIGIT;
				end else begin
					esc_state = PEND_NONE;
					n_broken++;
					emit_char(CH_PCT);
					plain_char(c);
				end
			end
			PEND_DIGIT: begin
				esc_state = PEND_NONE;
				if (is_hex_char(c)) begin
					v = {nibble_of(esc_digit), nibble_of(c)};
					if (!stays_escaped(v)) begin
						n_escapes++;
						emit_char(v);
					end else begin
						n_kept++;
						emit_char(CH_PCT);
						emit_char(esc_digit);
						emit_char(c);
					end
				end else begin
					n_broken++;
					emit_char(CH_PCT);
					emit_char(esc_digit);
					plain_char(c);
				end
			end
			default: begin
				esc_state = PEND_NONE;
				plain_char(c);
			end
		endcase
		if (eos) begin
			// flush whatever escape is still open at the end of the string
			if (esc_state == PEND_PCT) begin
				emit_char(CH_PCT);
			end else if (esc_state == PEND_DIGIT) begin
				emit_char(CH_PCT);
				emit_char(esc_digit);
			end
			esc_state = PEND_NONE;
			if (step_out.size() > 0) begin
				d = step_out[step_out.size() - 1];
				d.eos = 1'b1;
				step_out[step_out.size() - 1] = d;
			end
		end
		decoded_due = {decoded_due, step_out};
	endtask

	task automatic push_enc(input logic [7:0] c);
		enc_char_t e;
		e.ch    = c;
		e.eos   = 1'b0;
		e.drain = 1'b0;
		enc_chars = {enc_chars, e};
	endtask

	task automatic mark_end();
		enc_char_t e;
		e = enc_chars[enc_chars.size() - 1];
		e.eos = 1'b1;
		enc_chars[enc_chars.size() - 1] = e;
	endtask

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10)
			return CH_ZERO + 8'(v);
		else if ($urandom_range(0, 1))
			return CH_LO_A + 8'(v - 10);
		else
			return CH_UP_A + 8'(v - 10);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_hex_char(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// Well-formed escapes with random content, '+', high and random bytes, plus broken and truncated escapes
	task automatic add_string(input logic drain);
		int        n_tok;
		int        kind;
		int        first;
		enc_char_t e;
		first = enc_chars.size();
		n_tok = $urandom_range(1, 10);
		for (int t = 0; t < n_tok; t++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				push_enc(CH_PCT);
				push_enc(hex_char($urandom_range(0, 15)));
				push_enc(hex_char($urandom_range(0, 15)));
			end else if (kind < 50) begin
				push_enc(CH_PLUS);
			end else if (kind < 60) begin
				push_enc(CH_PCT);
				if ($urandom_range(0, 1))
					push_enc(hex_char($urandom_range(0, 15)));
				push_enc(non_hex_char());
			end else if (kind < 65) begin
				push_enc(8'($urandom_range(128, 255)));
			end else begin
				push_enc(8'($urandom_range(0, 255)));
			end
		end
		case ($urandom_range(0, 7))
			0: push_enc(CH_PCT);
			1: begin
				push_enc(CH_PCT);
				push_enc(hex_char($urandom_range(0, 15)));
			end
			default: ;
		endcase
		mark_end();
		if (drain) begin
			e = enc_chars[first];
			e.drain = 1'b1;
			enc_chars[first] = e;
		end
		strings_built++;
	endtask

	// Sender: predict on each accepted request, then offer the next byte or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_char(s_axis_tdata, s_axis_tlast);
				chars_sent++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (enc_chars.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					nxt = enc_chars[0];
					if (nxt.drain && decoded_due.size() != 0) begin
						s_axis_tvalid <= 1'b0;
					end else if (enc_chars.size() >= QUIET_TAIL &&
							$urandom_range(0, 4) == 0) begin
						gap_left = $urandom_range(0, 5);
						s_axis_tvalid <= 1'b0;
					end else begin
						void'(enc_chars.pop_front());
						s_axis_tvalid <= 1'b1;
						s_axis_tdata  <= nxt.ch;
						s_axis_tlast  <= nxt.eos;
					end
				end
			end
		end
	end

	// Receiver: check each accepted byte, stall in bursts, hold off once for long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				chars_seen++;
				if (decoded_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected output byte: expected none, actual 0x%02h last %0b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = decoded_due.pop_front();
					if (m_axis_tdata !== want.ch) begin
						errors++;
						$display("%0t: out_byte expected 0x%02h actual 0x%02h",
							$time, want.ch, m_axis_tdata);
					end
					if (m_axis_tlast !== want.eos) begin
						errors++;
						$display("%0t: out_last expected %0b actual %0b",
							$time, want.eos, m_axis_tlast);
					end
				end
			end
			if (!long_hold_done && chars_sent >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (enc_chars.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 5);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		// extremes of the byte, with a plain byte ending a string
		push_enc(8'h00);
		push_enc(8'hFF);
		mark_end();
		push_enc(CH_PLUS);
		// escape of a kept character stays literal; the next two escapes decode
		push_enc(CH_PCT); push_enc(CH_ZERO + 8'd4); push_enc(CH_ZERO + 8'd1);
		push_enc(CH_PCT); push_enc(CH_ZERO + 8'd2); push_enc(CH_ZERO);
		push_enc(CH_PCT); push_enc(CH_LO_A + 8'd4); push_enc(CH_NINE);
		// upper-case escape completed on the final byte
		push_enc(CH_PCT); push_enc(CH_ZERO + 8'd7); push_enc(CH_UP_F);
		mark_end();
		// broken escapes: '%' after '%', non-hex after '%' or after one digit, '+'
		push_enc(CH_PCT); push_enc(CH_PCT); push_enc(CH_UP_F + 8'd1);
		push_enc(CH_PCT); push_enc(CH_ZERO + 8'd3); push_enc(CH_LO_Z);
		push_enc(CH_PCT); push_enc(CH_PLUS);
		// escapes left open at the end of a string
		push_enc(CH_PCT);
		mark_end();
		push_enc(CH_PCT); push_enc(CH_LO_A);
		mark_end();

		while (enc_chars.size() < 26 + N_RANDOM)
			add_string(strings_built == 0 || strings_built == 25);
		n_items = enc_chars.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_sent != n_items)
			@(posedge clk);
		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d encoded bytes in %0d strings (plus directed cases);",
			n_items, strings_built);
		$display("checked %0d decoded bytes. Escapes: %0d decoded, %0d kept literal, %0d broken.",
			chars_seen, n_escapes, n_kept, n_broken);
		if (errors == 0)
			$display("url_percent_decoder: match");
		else
			$display("url_percent_decoder: mismatch");
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("%0t: timeout with %0d bytes still expected", $time, decoded_due.size());
		$display("url_percent_decoder: mismatch");
		$finish;
	end

endmodule
